### hw/rtl/ecf_pkg.sv
// ============================================================================
// ecf_pkg : Euler circuit finder package
// Shared sizes, configuration register indexes and payload types.
// ============================================================================
package ecf_pkg;

    localparam int MAX_VERTICES = 8;
    localparam int STACK_DEPTH  = 32;
    localparam int RESULT_CAP   = 29;

    localparam int ROW_W   = 8;
    localparam int VERT_W  = 3;
    localparam int NV_W    = 4;
    localparam int ADJ_AW  = $clog2(MAX_VERTICES);
    localparam int STK_AW  = $clog2(STACK_DEPTH);
    localparam int DEPTH_W = STK_AW + 1;
    localparam int RES_AW  = $clog2(RESULT_CAP);
    localparam int CNT_W   = $clog2(RESULT_CAP + 1);
    localparam int CFG_W   = 4;

    localparam logic [0:0] CFG_VERTEX_COUNT = 1'b0;
    localparam logic [0:0] CFG_START_VERTEX = 1'b1;

    localparam logic [NV_W-1:0] VERTEX_COUNT_RST = 4'd8;

    typedef struct packed {
        logic [VERT_W-1:0] row_index;
        logic [ROW_W-1:0]  row_bits;
        logic              last_row;
    } row_t;

    typedef struct packed {
        logic [VERT_W-1:0] vertex;
        logic              found;
        logic              final_res;
    } result_t;

endpackage

### hw/rtl/euler_circuit_finder_top.sv
// ============================================================================
// euler_circuit_finder_top : Hierholzer Euler circuit finder
// Stores adjacency rows, checks vertex degrees, walks the circuit with a
// stack held in memory and streams the circuit vertices out.
// ============================================================================
// Rows load at one transaction per cycle while the finder is idle; rows without last_row give nothing.
// After the last row: a read and an evaluate step per vertex for the degree check, then
// the pushes and pops of the walk (adjacency memory read-modify-write
// through one read and one write port), then each result is read and loaded, held while the output stalls.
// A fail result goes from the S_FAIL state into the result register once the output is free.
// Reset: asynchronous, active low; vertex_count 8, start_vertex 0; memories kept.
module euler_circuit_finder_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        row_valid,
    output logic                        row_ready,
    input  ecf_pkg::row_t               row,
    output logic                        result_valid,
    input  logic                        result_ready,
    output ecf_pkg::result_t            result,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [ecf_pkg::CFG_W-1:0]   cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK_RD,
        S_CHK_EV,
        S_WALK_RD,
        S_WALK_EV,
        S_WALK_NB,
        S_POP,
        S_OUT_RD,
        S_OUT_LD,
        S_FAIL
    } state_t;

    function automatic logic [ecf_pkg::ROW_W-1:0] vbit(input logic [ecf_pkg::VERT_W-1:0] v);
        return ecf_pkg::ROW_W'(1) << v;
    endfunction

    function automatic logic [ecf_pkg::NV_W-1:0] popcnt(input logic [ecf_pkg::ROW_W-1:0] x);
        logic [ecf_pkg::NV_W-1:0] c;
        c = '0;
        for (int b = 0; b < ecf_pkg::ROW_W; b++)
        begin
            c = c + ecf_pkg::NV_W'(x[b]);
        end
        return c;
    endfunction

    function automatic logic [ecf_pkg::VERT_W-1:0] lowbit(input logic [ecf_pkg::ROW_W-1:0] x);
        logic [ecf_pkg::VERT_W-1:0] j;
        j = '0;
        for (int b = ecf_pkg::ROW_W - 1; b >= 0; b--)
        begin
            if (x[b])
            begin
                j = ecf_pkg::VERT_W'(b);
            end
        end
        return j;
    endfunction

    // memories
    logic [ecf_pkg::ROW_W-1:0]  adj_mem [ecf_pkg::MAX_VERTICES];
    logic [ecf_pkg::VERT_W-1:0] stk_mem [ecf_pkg::STACK_DEPTH];
    logic [ecf_pkg::VERT_W-1:0] res_mem [ecf_pkg::RESULT_CAP];

    logic                         adj_we;
    logic [ecf_pkg::ADJ_AW-1:0]   adj_waddr, adj_raddr;
    logic [ecf_pkg::ROW_W-1:0]    adj_wdata, adj_rdata_reg;
    logic                         stk_we;
    logic [ecf_pkg::STK_AW-1:0]   stk_waddr, stk_raddr;
    logic [ecf_pkg::VERT_W-1:0]   stk_wdata, stk_rdata_reg;
    logic                         res_we;
    logic [ecf_pkg::RES_AW-1:0]   res_waddr, res_raddr;
    logic [ecf_pkg::VERT_W-1:0]   res_wdata, res_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[adj_waddr] <= adj_wdata;
        end
        adj_rdata_reg <= adj_mem[adj_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_rdata_reg <= stk_mem[stk_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (res_we)
        begin
            res_mem[res_waddr] <= res_wdata;
        end
        res_rdata_reg <= res_mem[res_raddr];
    end

    // control state
    state_t                        state_reg, state_next;
    logic [ecf_pkg::NV_W-1:0]      vcount_reg, vcount_next;
    logic [ecf_pkg::VERT_W-1:0]    start_reg, start_next;
    logic [ecf_pkg::VERT_W-1:0]    idx_reg, idx_next;
    logic [ecf_pkg::VERT_W-1:0]    top_reg, top_next;
    logic [ecf_pkg::VERT_W-1:0]    nbr_reg, nbr_next;
    logic [ecf_pkg::DEPTH_W-1:0]   depth_reg, depth_next;
    logic [ecf_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ecf_pkg::CNT_W-1:0]     oidx_reg, oidx_next;
    logic                          result_valid_reg, result_valid_next;
    ecf_pkg::result_t              result_reg, result_next;

    logic [ecf_pkg::NV_W-1:0]      nv;
    logic [ecf_pkg::ROW_W-1:0]     colmask;
    logic [ecf_pkg::ROW_W-1:0]     cand;
    logic [ecf_pkg::NV_W-1:0]      deg;
    logic                          out_free;

    always_comb
    begin
        if (vcount_reg == '0)
        begin
            nv = ecf_pkg::NV_W'(1);
        end
        else if (vcount_reg > ecf_pkg::NV_W'(ecf_pkg::MAX_VERTICES))
        begin
            nv = ecf_pkg::NV_W'(ecf_pkg::MAX_VERTICES);
        end
        else
        begin
            nv = vcount_reg;
        end
        for (int b = 0; b < ecf_pkg::ROW_W; b++)
        begin
            colmask[b] = (ecf_pkg::NV_W'(b) < nv);
        end
    end

    assign cand     = adj_rdata_reg & colmask & ~vbit(top_reg);
    assign deg      = popcnt(adj_rdata_reg & colmask);
    assign out_free = !result_valid_reg || result_ready;

    assign row_ready    = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        state_next        = state_reg;
        vcount_next       = vcount_reg;
        start_next        = start_reg;
        idx_next          = idx_reg;
        top_next          = top_reg;
        nbr_next          = nbr_reg;
        depth_next        = depth_reg;
        cnt_next          = cnt_reg;
        oidx_next         = oidx_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        adj_we    = 1'b0;
        adj_waddr = '0;
        adj_wdata = '0;
        adj_raddr = '0;
        stk_we    = 1'b0;
        stk_waddr = '0;
        stk_wdata = '0;
        stk_raddr = '0;
        res_we    = 1'b0;
        res_waddr = '0;
        res_wdata = '0;
        res_raddr = '0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                ecf_pkg::CFG_VERTEX_COUNT: vcount_next = cfg_data;
                ecf_pkg::CFG_START_VERTEX: start_next  = cfg_data[ecf_pkg::VERT_W-1:0];
                default: ;
            endcase
        end

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (row_valid)
                begin
                    adj_we    = 1'b1;
                    adj_waddr = row.row_index;
                    adj_wdata = row.row_bits;
                    if (row.last_row)
                    begin
                        idx_next   = '0;
                        state_next = S_CHK_RD;
                    end
                end
            end
            S_CHK_RD:
            begin
                adj_raddr  = idx_reg;
                state_next = S_CHK_EV;
            end
            S_CHK_EV:
            begin
                if (deg == '0 || deg[0])
                begin
                    state_next = S_FAIL;
                end
                else if (ecf_pkg::NV_W'(idx_reg) + ecf_pkg::NV_W'(1) == nv)
                begin
                    if (ecf_pkg::NV_W'(start_reg) >= nv)
                    begin
                        state_next = S_FAIL;
                    end
                    else
                    begin
                        stk_we     = 1'b1;
                        stk_waddr  = '0;
                        stk_wdata  = start_reg;
                        top_next   = start_reg;
                        depth_next = ecf_pkg::DEPTH_W'(1);
                        cnt_next   = '0;
                        state_next = S_WALK_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + ecf_pkg::VERT_W'(1);
                    state_next = S_CHK_RD;
                end
            end
            S_WALK_RD:
            begin
                adj_raddr  = top_reg;
                state_next = S_WALK_EV;
            end
            S_WALK_EV:
            begin
                if (cand != '0)
                begin
                    // clear u->j now, fetch row j for the mirror bit
                    adj_we     = 1'b1;
                    adj_waddr  = top_reg;
                    adj_wdata  = adj_rdata_reg & ~vbit(lowbit(cand));
                    adj_raddr  = lowbit(cand);
                    nbr_next   = lowbit(cand);
                    state_next = S_WALK_NB;
                end
                else if (cnt_reg >= ecf_pkg::CNT_W'(ecf_pkg::RESULT_CAP))
                begin
                    state_next = S_FAIL;
                end
                else
                begin
                    res_we     = 1'b1;
                    res_waddr  = cnt_reg[ecf_pkg::RES_AW-1:0];
                    res_wdata  = top_reg;
                    cnt_next   = cnt_reg + ecf_pkg::CNT_W'(1);
                    depth_next = depth_reg - ecf_pkg::DEPTH_W'(1);
                    if (depth_reg == ecf_pkg::DEPTH_W'(1))
                    begin
                        oidx_next  = '0;
                        state_next = S_OUT_RD;
                    end
                    else
                    begin
                        stk_raddr  = ecf_pkg::STK_AW'(depth_reg - ecf_pkg::DEPTH_W'(2));
                        state_next = S_POP;
                    end
                end
            end
            S_WALK_NB:
            begin
                adj_we    = 1'b1;
                adj_waddr = nbr_reg;
                adj_wdata = adj_rdata_reg & ~vbit(top_reg);
                if (depth_reg >= ecf_pkg::DEPTH_W'(ecf_pkg::STACK_DEPTH))
                begin
                    state_next = S_FAIL;
                end
                else
                begin
                    stk_we     = 1'b1;
                    stk_waddr  = depth_reg[ecf_pkg::STK_AW-1:0];
                    stk_wdata  = nbr_reg;
                    depth_next = depth_reg + ecf_pkg::DEPTH_W'(1);
                    top_next   = nbr_reg;
                    state_next = S_WALK_RD;
                end
            end
            S_POP:
            begin
                top_next   = stk_rdata_reg;
                state_next = S_WALK_RD;
            end
            S_OUT_RD:
            begin
                res_raddr  = oidx_reg[ecf_pkg::RES_AW-1:0];
                state_next = S_OUT_LD;
            end
            S_OUT_LD:
            begin
                // hold the read address so a stalled output keeps its entry
                res_raddr = oidx_reg[ecf_pkg::RES_AW-1:0];
                if (out_free)
                begin
                    result_valid_next     = 1'b1;
                    result_next.vertex    = res_rdata_reg;
                    result_next.found     = 1'b1;
                    result_next.final_res = (oidx_reg + ecf_pkg::CNT_W'(1) == cnt_reg);
                    if (oidx_reg + ecf_pkg::CNT_W'(1) == cnt_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        oidx_next  = oidx_reg + ecf_pkg::CNT_W'(1);
                        state_next = S_OUT_RD;
                    end
                end
            end
            S_FAIL:
            begin
                depth_next = '0;
                if (out_free)
                begin
                    result_valid_next     = 1'b1;
                    result_next.vertex    = '0;
                    result_next.found     = 1'b0;
                    result_next.final_res = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            vcount_reg       <= ecf_pkg::VERTEX_COUNT_RST;
            start_reg        <= '0;
            depth_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            vcount_reg       <= vcount_next;
            start_reg        <= start_next;
            depth_reg        <= depth_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        top_reg    <= top_next;
        nbr_reg    <= nbr_next;
        cnt_reg    <= cnt_next;
        oidx_reg   <= oidx_next;
        result_reg <= result_next;
    end

    // checks
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= ecf_pkg::DEPTH_W'(ecf_pkg::STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        row_ready |-> depth_reg == '0)
        else $error("stack not empty while taking rows");

    a_fail_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.found |-> result.final_res && result.vertex == '0)
        else $error("malformed fail result");

    a_walk_has_top: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK_RD || state_reg == S_WALK_NB) |-> depth_reg != '0)
        else $error("walk step with empty stack");

    a_load_gated: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_reg) || !result_valid_reg)
        else $error("pending result overwritten");

endmodule

### test/ecf_circuit_checker.sv
// ============================================================================
// ecf_circuit_checker : result checker for the Euler circuit finder
// Watches the configuration port and both channels, keeps its own copy of
// the adjacency matrix and the registers, predicts the circuit or the fail
// result for every last row and compares each result transaction in order.
// ============================================================================
module ecf_circuit_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        row_valid,
    input  logic                        row_ready,
    input  ecf_pkg::row_t               row,
    input  logic                        result_valid,
    input  logic                        result_ready,
    input  ecf_pkg::result_t            result,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [ecf_pkg::CFG_W-1:0]   cfg_data,
    output int                          mismatch_count,
    output int                          results_due
);

    timeunit 1ns;
    timeprecision 1ps;

    logic [ecf_pkg::ROW_W-1:0]  adj_rows [ecf_pkg::MAX_VERTICES];
    logic [ecf_pkg::NV_W-1:0]   vcount_reg = ecf_pkg::VERTEX_COUNT_RST;
    logic [ecf_pkg::VERT_W-1:0] start_reg = '0;
    ecf_pkg::result_t           circuit_due [$];
    ecf_pkg::result_t           want;

    initial mismatch_count = 0;
    initial results_due = 0;

    task automatic flag(input string msg);
        mismatch_count++;
        $display("%0t ns  mismatch: %s", $time, msg);
    endtask

    // Degree check, then the stack walk; clears the edges it takes.
    task automatic predict_circuit();
        int n;
        int sp;
        int u;
        int j;
        bit failed;
        logic [ecf_pkg::ROW_W-1:0]  cols;
        logic [ecf_pkg::ROW_W-1:0]  cand;
        logic [ecf_pkg::VERT_W-1:0] stk [ecf_pkg::STACK_DEPTH];
        ecf_pkg::result_t           walk_out [$];
        ecf_pkg::result_t           r;
        failed = 1'b0;
        n = int'(vcount_reg);
        if (n < 1)
            n = 1;
        if (n > ecf_pkg::MAX_VERTICES)
            n = ecf_pkg::MAX_VERTICES;
        cols = ecf_pkg::ROW_W'((1 << n) - 1);
        for (int i = 0; i < n; i++)
        begin
            if ($countones(adj_rows[i] & cols) == 0 || $countones(adj_rows[i] & cols) % 2 != 0)
                failed = 1'b1;
        end
        if (!failed && int'(start_reg) >= n)
            failed = 1'b1;
        if (!failed)
        begin
            stk[0] = start_reg;
            sp = 1;
            while (sp > 0 && !failed)
            begin
                u = int'(stk[sp-1]);
                cand = adj_rows[u] & cols & ~(ecf_pkg::ROW_W'(1) << u);
                if (cand != '0)
                begin
                    j = 0;
                    while (!cand[j])
                        j++;
                    adj_rows[u][j] = 1'b0;
                    adj_rows[j][u] = 1'b0;
                    if (sp >= ecf_pkg::STACK_DEPTH)
                        failed = 1'b1;
                    else
                    begin
                        stk[sp] = ecf_pkg::VERT_W'(j);
                        sp++;
                    end
                end
                else if (walk_out.size() >= ecf_pkg::RESULT_CAP)
                    failed = 1'b1;
                else
                begin
                    r.vertex = ecf_pkg::VERT_W'(u);
                    r.found = 1'b1;
                    r.final_res = 1'b0;
                    walk_out = {walk_out, r};
                    sp--;
                end
            end
        end
        if (failed)
        begin
            r = '0;
            r.final_res = 1'b1;
            circuit_due = {circuit_due, r};
        end
        else
        begin
            for (int k = 0; k < walk_out.size(); k++)
            begin
                r = walk_out[k];
                r.final_res = (k == walk_out.size() - 1);
                circuit_due = {circuit_due, r};
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg = ecf_pkg::VERTEX_COUNT_RST;
            start_reg = '0;
            circuit_due.delete();
            results_due <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == ecf_pkg::CFG_VERTEX_COUNT)
                    vcount_reg = cfg_data[ecf_pkg::NV_W-1:0];
                else if (cfg_index == ecf_pkg::CFG_START_VERTEX)
                    start_reg = cfg_data[ecf_pkg::VERT_W-1:0];
            end
            if (result_valid && result_ready)
            begin
                if (circuit_due.size() == 0)
                    flag($sformatf("unexpected transaction vertex=%0d found=%0b final_res=%0b",
                                   result.vertex, result.found, result.final_res));
                else
                begin
                    want = circuit_due.pop_front();
                    if (result.vertex !== want.vertex)
                        flag($sformatf("vertex %0d, expected %0d", result.vertex, want.vertex));
                    if (result.found !== want.found)
                        flag($sformatf("found %0b, expected %0b", result.found, want.found));
                    if (result.final_res !== want.final_res)
                        flag($sformatf("final_res %0b, expected %0b",
                                       result.final_res, want.final_res));
                end
            end
            if (row_valid && row_ready)
            begin
                adj_rows[row.row_index] = row.row_bits;
                if (row.last_row)
                    predict_circuit();
            end
            results_due <= circuit_due.size();
        end
    end

endmodule

### test/tb_euler_circuit_finder_top.sv
// ============================================================================
// tb_euler_circuit_finder_top : testbench for the Euler circuit finder
// Directed graphs first (full matrix, odd and zero degree, start outside the
// graph, out-of-range vertex counts, stray columns), then random Eulerian,
// self-loop, odd, asymmetric and noise matrices and single-row reruns under varying settings with
// random stalls on both channels. Checking is done by ecf_circuit_checker.
// ============================================================================
module tb_euler_circuit_finder_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ITEMS    = 210;
    localparam int QUIET_FROM = 180;
    localparam int LIMIT      = 1000000;

    typedef enum int {
        SHAPE_EULER,
        SHAPE_LOOPS,
        SHAPE_ODD,
        SHAPE_ASYM,
        SHAPE_NOISE,
        SHAPE_RERUN
    } shape_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       row_valid = 1'b0;
    logic                       row_ready;
    ecf_pkg::row_t              row = '0;
    logic                       result_valid;
    logic                       result_ready = 1'b0;
    ecf_pkg::result_t           result;
    logic                       cfg_we = 1'b0;
    logic [0:0]                 cfg_index = ecf_pkg::CFG_VERTEX_COUNT;
    logic [ecf_pkg::CFG_W-1:0]  cfg_data = '0;

    logic              idle_on = 1'b1;
    int                rx_hold = 0;
    int                sent = 0;
    int unsigned       cycle_count = 0;
    int                mismatch_count;
    int                results_due;

    logic [ecf_pkg::ROW_W-1:0]  mat [ecf_pkg::MAX_VERTICES];
    int                         perm [ecf_pkg::MAX_VERTICES];

    euler_circuit_finder_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .row_valid    (row_valid),
        .row_ready    (row_ready),
        .row          (row),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    ecf_circuit_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .row_valid      (row_valid),
        .row_ready      (row_ready),
        .row            (row),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result         (result),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side back-pressure in bursts.
    always @(posedge clk)
    begin
        if (!idle_on)
            result_ready <= 1'b1;
        else if (rx_hold > 0)
        begin
            rx_hold <= rx_hold - 1;
            result_ready <= (rx_hold == 1);
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            rx_hold <= $urandom_range(1, 18);
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    task automatic send_row(input int idx, input logic [ecf_pkg::ROW_W-1:0] bits,
                            input bit last);
        ecf_pkg::row_t r;
        r.row_index = ecf_pkg::VERT_W'(idx);
        r.row_bits = bits;
        r.last_row = last;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            row_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        row <= r;
        row_valid <= 1'b1;
        @(posedge clk);
        while (!row_ready)
            @(posedge clk);
        sent++;
    endtask

    // Sender holds off until every outstanding transaction has come back.
    task automatic drain();
        row_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_config(input int nv, input int sv);
        cfg_we <= 1'b1;
        cfg_index <= ecf_pkg::CFG_VERTEX_COUNT;
        cfg_data <= ecf_pkg::CFG_W'(nv);
        @(posedge clk);
        cfg_index <= ecf_pkg::CFG_START_VERTEX;
        cfg_data <= ecf_pkg::CFG_W'(sv);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic shuffle(input int n);
        int k;
        int t;
        for (int i = 0; i < n; i++)
            perm[i] = i;
        for (int i = n - 1; i > 0; i--)
        begin
            k = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[k];
            perm[k] = t;
        end
    endtask

    task automatic toggle_edge(input int a, input int b);
        mat[a][b] = ~mat[a][b];
        mat[b][a] = ~mat[b][a];
    endtask

    task automatic build_base(input int n);
        int len;
        for (int i = 0; i < ecf_pkg::MAX_VERTICES; i++)
            mat[i] = '0;
        if (n >= 3)
        begin
            shuffle(n);
            for (int k = 0; k < n; k++)
                toggle_edge(perm[k], perm[(k + 1) % n]);
            repeat ($urandom_range(0, 2))
            begin
                shuffle(n);
                len = $urandom_range(3, n);
                for (int k = 0; k < len; k++)
                    toggle_edge(perm[k], perm[(k + 1) % len]);
            end
        end
        else if (n == 2)
        begin
            mat[0] = 8'h03;
            mat[1] = 8'h03;
        end
        else
            mat[0] = ecf_pkg::ROW_W'($urandom_range(0, 255));
    endtask

    task automatic send_graph(input int n);
        shape_t shape;
        int pick;
        int a;
        int b;
        int c;
        int len;
        logic [ecf_pkg::ROW_W-1:0] cols;
        logic [ecf_pkg::ROW_W-1:0] bits;
        pick = $urandom_range(0, 11);
        case (pick) inside
            [0:4]:   shape = SHAPE_EULER;
            [5:6]:   shape = SHAPE_LOOPS;
            7:       shape = SHAPE_ODD;
            [8:9]:   shape = SHAPE_ASYM;
            10:      shape = SHAPE_NOISE;
            default: shape = SHAPE_RERUN;
        endcase
        build_base(n);
        cols = ecf_pkg::ROW_W'((1 << n) - 1);
        case (shape)
            SHAPE_LOOPS:
                if (n >= 2)
                begin
                    shuffle(n);
                    len = $urandom_range(2, n);
                    for (int k = 0; k < len - 1; k++)
                        toggle_edge(perm[k], perm[k + 1]);
                    mat[perm[0]][perm[0]] = ~mat[perm[0]][perm[0]];
                    mat[perm[len-1]][perm[len-1]] = ~mat[perm[len-1]][perm[len-1]];
                end
            SHAPE_ODD:
            begin
                a = $urandom_range(0, n - 1);
                b = $urandom_range(0, n - 1);
                mat[a][b] = ~mat[a][b];
            end
            SHAPE_ASYM:
                if (n >= 2)
                begin
                    a = $urandom_range(0, n - 1);
                    b = $urandom_range(0, n - 1);
                    c = (b + $urandom_range(1, n - 1)) % n;
                    mat[a][b] = ~mat[a][b];
                    mat[a][c] = ~mat[a][c];
                end
            SHAPE_NOISE:
                for (int i = 0; i < ecf_pkg::MAX_VERTICES; i++)
                    mat[i] = ecf_pkg::ROW_W'($urandom_range(0, 255));
            default: ;
        endcase
        if (shape == SHAPE_RERUN)
        begin
            a = $urandom_range(0, n - 1);
            send_row(a, mat[a], 1'b1);
            return;
        end
        for (int i = n; i < ecf_pkg::MAX_VERTICES; i++)
            if ($urandom_range(0, 3) == 0)
                send_row(i, ecf_pkg::ROW_W'($urandom_range(0, 255)), 1'b0);
        shuffle(n);
        for (int k = 0; k < n; k++)
        begin
            bits = mat[perm[k]];
            if ($urandom_range(0, 3) == 0)
                bits = bits | (ecf_pkg::ROW_W'($urandom_range(0, 255)) & ~cols);
            send_row(perm[k], bits, k == n - 1);
        end
    endtask

    initial
    begin
        int nv;
        int neff;
        int sv;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full matrix with every diagonal set: longest circuit
        for (int i = 0; i < ecf_pkg::MAX_VERTICES; i++)
            send_row(i, 8'hFF, i == ecf_pkg::MAX_VERTICES - 1);
        drain();
        // single vertex, odd degree
        set_config(1, 0);
        send_row(0, 8'h01, 1'b1);
        drain();
        // two vertices with self loops, stray high columns, start at 1
        set_config(2, 1);
        send_row(0, 8'hF3, 1'b0);
        send_row(1, 8'h03, 1'b1);
        drain();
        // valid triangle, start outside the graph
        set_config(3, 7);
        send_row(0, 8'h06, 1'b0);
        send_row(1, 8'h05, 1'b0);
        send_row(2, 8'h03, 1'b1);
        drain();
        // vertex count 0 taken as 1: zero degree, then odd degree
        set_config(0, 0);
        send_row(0, 8'h00, 1'b1);
        drain();
        send_row(0, 8'h01, 1'b1);
        drain();
        // vertex count above range taken as 8: ring from vertex 7
        set_config(15, 7);
        for (int i = 0; i < ecf_pkg::MAX_VERTICES; i++)
            send_row(i, ecf_pkg::ROW_W'((1 << ((i + 1) % 8)) | (1 << ((i + 7) % 8))),
                     i == ecf_pkg::MAX_VERTICES - 1);

        while (sent < N_ITEMS)
        begin
            drain();
            if (sent >= QUIET_FROM)
                idle_on <= 1'b0;
            else
                idle_on <= ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0:       nv = $urandom_range(0, 2);
                1:       nv = $urandom_range(9, 15);
                default: nv = $urandom_range(3, 8);
            endcase
            neff = (nv < 1) ? 1 : (nv > ecf_pkg::MAX_VERTICES) ? ecf_pkg::MAX_VERTICES : nv;
            if ($urandom_range(0, 7) == 0)
                sv = $urandom_range(0, 7);
            else
                sv = $urandom_range(0, neff - 1);
            set_config(nv, sv);
            repeat ($urandom_range(1, 3))
                send_graph(neff);
        end

        row_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatch_count == 0 && results_due == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
hw/rtl/ecf_pkg.sv
hw/rtl/euler_circuit_finder_top.sv
test/ecf_circuit_checker.sv
test/tb_euler_circuit_finder_top.sv
